@@ design/msc_pkg.sv @@
// Shared types and constants for the MIPS-subset core.
// Opcode and funct codes, register numbers, syscall codes, memory request type.
// No dependencies.
package msc_pkg;

    localparam int REG_AW = 5;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ORI   = 6'h0D;
    localparam logic [5:0] OP_LUI   = 6'h0F;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;

    localparam logic [5:0] FN_MUL     = 6'h02;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SLT     = 6'h2A;

    localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
    localparam logic [REG_AW-1:0] REG_V0   = 5'd2;
    localparam logic [REG_AW-1:0] REG_A0   = 5'd4;
    localparam logic [REG_AW-1:0] REG_SP   = 5'd29;
    localparam logic [REG_AW-1:0] REG_RA   = 5'd31;

    localparam logic [31:0] SYS_PRINT = 32'd1;
    localparam logic [31:0] SYS_READ  = 32'd5;
    localparam logic [31:0] SYS_EXIT  = 32'd10;

    localparam logic       CFG_START_PC   = 1'b0;
    localparam logic       CFG_INIT_STACK = 1'b1;
    localparam logic [15:0] SP_RESET      = 16'd65000;

    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [31:0] addr;
        logic [31:0] wdata;
    } dmem_req_t;

endpackage

@@ design/msc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module msc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/msc_regfile.sv @@
// Register bank: two RAM copies for two read ports, valid bits for reset values.
// Depends on msc_pkg and msc_ram.
module msc_regfile
    import msc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              re,
    input  logic [REG_AW-1:0] raddr_a,
    input  logic [REG_AW-1:0] raddr_b,
    input  logic              we,
    input  logic [REG_AW-1:0] waddr,
    input  logic [31:0]       wdata,
    input  logic [15:0]       sp_init,
    output logic [31:0]       rdata_a,
    output logic [31:0]       rdata_b
);

    logic [31:0] valid_reg;
    logic        va_reg, vb_reg, sa_reg, sb_reg;
    logic [31:0] ram_a, ram_b;

    msc_ram #(.WIDTH(32), .DEPTH(32)) u_ram_a (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .re(re), .raddr(raddr_a), .rdata(ram_a)
    );

    msc_ram #(.WIDTH(32), .DEPTH(32)) u_ram_b (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .re(re), .raddr(raddr_b), .rdata(ram_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            sa_reg    <= 1'b0;
            sb_reg    <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                va_reg <= valid_reg[raddr_a];
                vb_reg <= valid_reg[raddr_b];
                sa_reg <= (raddr_a == REG_SP);
                sb_reg <= (raddr_b == REG_SP);
            end
        end
    end

    // never-written entries read as their reset value
    assign rdata_a = va_reg ? ram_a : (sa_reg ? {16'd0, sp_init} : 32'd0);
    assign rdata_b = vb_reg ? ram_b : (sb_reg ? {16'd0, sp_init} : 32'd0);

endmodule

@@ design/msc_dmem.sv @@
// Byte data memory as four byte lanes; steers unaligned little-endian words.
// Depends on msc_pkg and msc_ram.
module msc_dmem
    import msc_pkg::*;
#(
    parameter int MEM_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        re,
    input  dmem_req_t   req,
    output logic [31:0] rdata
);

    localparam int ADDR_W = $clog2(MEM_BYTES);
    localparam int ROWS   = MEM_BYTES / 4;

    logic [1:0] off_reg;
    logic [7:0] lane_q [4];

    genvar l;
    generate
        for (l = 0; l < 4; l++)
        begin : g_lane
            logic [1:0]        k;
            logic [31:0]       baddr;
            logic [ADDR_W-3:0] row;
            logic [7:0]        wbyte;

            assign k     = 2'(l) - req.addr[1:0];
            assign baddr = req.addr + {30'd0, k};
            assign row   = baddr[ADDR_W-1:2];
            assign wbyte = 8'(req.wdata >> {k, 3'b000});

            msc_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane (
                .clk(clk), .we(req.wr), .waddr(row), .wdata(wbyte),
                .re(re && req.rd), .raddr(row), .rdata(lane_q[l])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= 2'd0;
        end
        else if (re && req.rd)
        begin
            off_reg <= req.addr[1:0];
        end
    end

    assign rdata = {lane_q[off_reg + 2'd3], lane_q[off_reg + 2'd2],
                    lane_q[off_reg + 2'd1], lane_q[off_reg]};

endmodule

@@ design/mips_subset_single_cycle_core.sv @@
// MIPS-subset core: one instruction word per input item, one result item each.
// Items pass the execute+memory, writeback and output registers; one item per cycle while
// the output does not stall, via register read / execute+memory / writeback with forwarding.
// Reset: PC = 0 (start_pc by cfg), registers zero except r29 = initial_stack (valid bits),
// not halted; data memory is not cleared and holds garbage until written.
// Depends on msc_pkg, msc_regfile, msc_dmem.
module mips_subset_single_cycle_core
    import msc_pkg::*;
#(
    parameter int MEM_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // instruction, read_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // next_pc, stopped, print_value, unknown_instruction
    output logic        m_axis_tuser    // print_valid
);

    logic advance, accept;
    logic [31:0] in_ins;
    logic in_sys;
    logic [REG_AW-1:0] in_ra, in_rb;

    logic        x_valid_reg;
    logic [31:0] x_ins_reg, x_rdv_reg;
    logic [REG_AW-1:0] x_ra_reg, x_rb_reg;

    logic [31:0] pc_reg;
    logic        halted_reg, any_step_reg;
    logic [15:0] stack_init_reg;

    logic        m_valid_reg, m_wen_reg, m_load_reg;
    logic [REG_AW-1:0] m_waddr_reg;
    logic [31:0] m_wdata_reg, m_next_pc_reg, m_pv_reg;
    logic        m_stopped_reg, m_pvalid_reg, m_unk_reg;

    logic        out_valid_reg;
    logic [31:0] out_next_pc_reg, out_pv_reg;
    logic        out_stopped_reg, out_pvalid_reg, out_unk_reg;

    logic        last_wen_reg;
    logic [REG_AW-1:0] last_addr_reg;
    logic [31:0] last_data_reg;

    logic [31:0] rf_a, rf_b, dmem_rdata, m_result, a, b;
    logic        rf_we;
    dmem_req_t   dreq;

    logic [5:0]  op, fn;
    logic [REG_AW-1:0] rt, rd;
    logic [31:0] sx, pc4, x_next_pc, x_wdata, x_pv;
    logic        x_stopped, x_pvalid, x_unk, x_wen, x_load, x_halt, x_rd, x_wr;
    logic [REG_AW-1:0] x_waddr;
    logic [31:0] x_addr;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && advance;
    assign s_axis_tready = advance;

    // syscall reads v0 and a0 instead of its rs/rt fields
    assign in_ins = s_axis_tdata[31:0];
    assign in_sys = (in_ins[31:26] == OP_RTYPE) && (in_ins[5:0] == FN_SYSCALL);
    assign in_ra  = in_sys ? REG_V0 : in_ins[25:21];
    assign in_rb  = in_sys ? REG_A0 : in_ins[20:16];

    assign m_result = m_load_reg ? dmem_rdata : m_wdata_reg;
    assign rf_we    = advance && m_valid_reg && m_wen_reg;

    msc_regfile u_regfile (
        .clk(clk), .rst_n(rst_n), .re(advance),
        .raddr_a(in_ra), .raddr_b(in_rb),
        .we(rf_we), .waddr(m_waddr_reg), .wdata(m_result),
        .sp_init(stack_init_reg),
        .rdata_a(rf_a), .rdata_b(rf_b)
    );

    msc_dmem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
        .clk(clk), .rst_n(rst_n), .re(advance), .req(dreq), .rdata(dmem_rdata)
    );

    // operand forwarding: instruction in writeback, then the one just retired
    always_comb
    begin
        if (m_valid_reg && m_wen_reg && m_waddr_reg == x_ra_reg)
            a = m_result;
        else if (last_wen_reg && last_addr_reg == x_ra_reg)
            a = last_data_reg;
        else
            a = rf_a;
        if (m_valid_reg && m_wen_reg && m_waddr_reg == x_rb_reg)
            b = m_result;
        else if (last_wen_reg && last_addr_reg == x_rb_reg)
            b = last_data_reg;
        else
            b = rf_b;
    end

    assign op  = x_ins_reg[31:26];
    assign fn  = x_ins_reg[5:0];
    assign rt  = x_ins_reg[20:16];
    assign rd  = x_ins_reg[15:11];
    assign sx  = {{16{x_ins_reg[15]}}, x_ins_reg[15:0]};
    assign pc4 = pc_reg + 32'd4;

    always_comb
    begin
        x_next_pc = pc4;
        x_stopped = 1'b0;
        x_pvalid  = 1'b0;
        x_pv      = 32'd0;
        x_unk     = 1'b0;
        x_wen     = 1'b0;
        x_waddr   = rt;
        x_wdata   = 32'd0;
        x_load    = 1'b0;
        x_halt    = 1'b0;
        x_rd      = 1'b0;
        x_wr      = 1'b0;
        x_addr    = a + sx;
        if (halted_reg || x_ins_reg == 32'd0)
        begin
            x_halt = 1'b1;
        end
        else
        begin
            unique case (op)
                OP_RTYPE:
                begin
                    x_waddr = rd;
                    unique case (fn)
                        FN_SYSCALL:
                        begin
                            if (a == SYS_PRINT)
                            begin
                                x_pvalid = 1'b1;
                                x_pv     = b;
                            end
                            else if (a == SYS_READ)
                            begin
                                x_wen   = 1'b1;
                                x_waddr = REG_V0;
                                x_wdata = x_rdv_reg;
                            end
                            else if (a == SYS_EXIT)
                            begin
                                x_halt = 1'b1;
                            end
                        end
                        FN_ADD: begin x_wen = 1'b1; x_wdata = a + b; end
                        FN_SUB: begin x_wen = 1'b1; x_wdata = a - b; end
                        FN_MUL: begin x_wen = 1'b1; x_wdata = a * b; end
                        FN_SLT:
                        begin
                            x_wen   = 1'b1;
                            x_wdata = {31'd0, $signed(a) < $signed(b)};
                        end
                        FN_JR:  x_next_pc = a;
                        default: x_unk = 1'b1;
                    endcase
                end
                OP_ORI:  begin x_wen = 1'b1; x_wdata = a | sx; end
                OP_LUI:  begin x_wen = 1'b1; x_wdata = {x_ins_reg[15:0], 16'd0}; end
                OP_ADDI: begin x_wen = 1'b1; x_wdata = a + sx; end
                OP_LW:   begin x_wen = 1'b1; x_load = 1'b1; x_rd = 1'b1; end
                OP_SW:   x_wr = 1'b1;
                OP_BEQ:
                begin
                    if (a == b)
                        x_next_pc = pc4 + {sx[29:0], 2'b00};
                end
                OP_J:    x_next_pc = {4'd0, x_ins_reg[25:0], 2'b00};
                OP_JAL:
                begin
                    x_wen     = 1'b1;
                    x_waddr   = REG_RA;
                    x_wdata   = pc4;
                    x_next_pc = {4'd0, x_ins_reg[25:0], 2'b00};
                end
                default: x_unk = 1'b1;
            endcase
        end
        if (x_halt)
        begin
            x_next_pc = pc_reg;
            x_stopped = 1'b1;
        end
    end

    assign dreq.rd    = x_rd;
    assign dreq.wr    = advance && x_valid_reg && x_wr;
    assign dreq.addr  = x_addr;
    assign dreq.wdata = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_wen_reg      <= 1'b0;
            m_load_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_wen_reg   <= 1'b0;
            pc_reg         <= 32'd0;
            halted_reg     <= 1'b0;
            any_step_reg   <= 1'b0;
            stack_init_reg <= SP_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_START_PC:
                    begin
                        if (!any_step_reg)
                            pc_reg <= {16'd0, cfg_wdata};
                    end
                    CFG_INIT_STACK:
                    begin
                        if (!any_step_reg)
                            stack_init_reg <= cfg_wdata;
                    end
                    default: ;
                endcase
            end
            if (advance)
            begin
                x_valid_reg   <= accept;
                m_valid_reg   <= x_valid_reg;
                m_wen_reg     <= x_valid_reg && x_wen && (x_waddr != REG_ZERO);
                m_load_reg    <= x_load;
                out_valid_reg <= m_valid_reg;
                last_wen_reg  <= m_valid_reg && m_wen_reg;
                if (x_valid_reg)
                begin
                    pc_reg       <= x_next_pc;
                    halted_reg   <= halted_reg || x_halt;
                    any_step_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_ins_reg <= in_ins;
            x_rdv_reg <= s_axis_tdata[63:32];
            x_ra_reg  <= in_ra;
            x_rb_reg  <= in_rb;
        end
        if (advance)
        begin
            m_waddr_reg     <= x_waddr;
            m_wdata_reg     <= x_wdata;
            m_next_pc_reg   <= x_next_pc;
            m_stopped_reg   <= x_stopped;
            m_pvalid_reg    <= x_pvalid;
            m_pv_reg        <= x_pv;
            m_unk_reg       <= x_unk;
            out_next_pc_reg <= m_next_pc_reg;
            out_stopped_reg <= m_stopped_reg;
            out_pvalid_reg  <= m_pvalid_reg;
            out_pv_reg      <= m_pv_reg;
            out_unk_reg     <= m_unk_reg;
            last_addr_reg   <= m_waddr_reg;
            last_data_reg   <= m_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_unk_reg, out_pv_reg, out_stopped_reg, out_next_pc_reg};
    assign m_axis_tuser  = out_pvalid_reg;

endmodule
